[design/alsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_pkg: shared definitions for the antialiased line stepper
// Default geometry, opacity reset value, command codes and queue status.
// ----------------------------------------------------------------------------
package alsp_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OPACITY_W      = 8;
  localparam logic [OPACITY_W-1:0] OPACITY_RESET = 8'hFF;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } q_stat_t;

endpackage

[design/alsp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_front: command intake and endpoint classification
// Accepts input beats, picks the major axis, orders endpoints by major
// coordinate and pushes a decoded command into the queue.
// ----------------------------------------------------------------------------
module alsp_front #(
  parameter int COORD_BITS = alsp_pkg::COORD_BITS_DEF,
  parameter int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
  parameter int ENTRY_W    = 3 + 9 * COORD_BITS
) (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic [0:0]           in_tuser,
  input  alsp_pkg::q_stat_t    q_stat,
  output logic                 push,
  output logic [ENTRY_W-1:0]   push_data
);

  localparam int C = COORD_BITS;

  logic [C-1:0] sx, sy, ex, ey;
  logic [C-1:0] adx, ady;
  logic         steep;
  logic [C-1:0] a0u, b0u, a1u, b1u;
  logic         swap;
  logic [C-1:0] a0, b0, a1, b1;
  logic [C-1:0] span, mag;
  logic         neg;
  alsp_pkg::cmd_t kind;

  assign sx = in_tdata[C-1:0];
  assign sy = in_tdata[2*C-1:C];
  assign ex = in_tdata[3*C-1:2*C];
  assign ey = in_tdata[4*C-1:3*C];

  assign kind = alsp_pkg::cmd_t'(in_tuser[0]);

  always_comb begin
    adx   = (sx > ex) ? (sx - ex) : (ex - sx);
    ady   = (sy > ey) ? (sy - ey) : (ey - sy);
    steep = ady > adx;
    // swap axes for steep lines
    a0u = steep ? sy : sx;
    b0u = steep ? sx : sy;
    a1u = steep ? ey : ex;
    b1u = steep ? ex : ey;
    swap = a1u < a0u;
    a0 = swap ? a1u : a0u;
    b0 = swap ? b1u : b0u;
    a1 = swap ? a0u : a1u;
    b1 = swap ? b0u : b1u;
    span = a1 - a0;
    neg  = b1 < b0;
    mag  = neg ? (b0 - b1) : (b1 - b0);
  end

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;
  assign push_data = {kind, steep, neg, a0, a1, b0, mag, span, sx, sy, ex, ey};

endmodule

[design/alsp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_fifo: short command queue between front and back
// Show-ahead register queue; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module alsp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = alsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      push_data,
  input  logic              pop,
  output logic [W-1:0]      head_data,
  output alsp_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign head_data         = mem[rd_ptr_r];
  assign q_stat.head_valid = cnt_r != '0;
  assign q_stat.full       = cnt_r == CNT_W'(DEPTH);

endmodule

[design/alsp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_back: line state, gradient divider and pixel emission
// Runs queued commands: endpoint pixels and a serial gradient divide on
// load, two pixels per step, alpha scaling and the output register.
// ----------------------------------------------------------------------------
module alsp_back #(
  parameter int COORD_BITS = alsp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alsp_pkg::FRAC_BITS_DEF,
  parameter int OUT_W      = ((2 * (COORD_BITS + 1) + 8 + 7) / 8) * 8,
  parameter int ENTRY_W    = 3 + 9 * COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ENTRY_W-1:0]            head_data,
  input  alsp_pkg::q_stat_t             q_stat,
  output logic                          pop,
  input  logic                          cfg_valid,
  input  logic [alsp_pkg::OPACITY_W-1:0] cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata,
  output logic                          out_tlast
);

  localparam int C      = COORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int OW     = alsp_pkg::OPACITY_W;
  localparam int ACC_W  = C + F + 1;
  localparam int GRAD_W = F + 2;
  localparam int CNT_W  = $clog2(F + 1);
  localparam int PROD_W = OW + F + 1;
  localparam int PIX_BITS = 2 * (C + 1) + OW;
  localparam logic [F:0] COV_ONE    = {1'b1, {F{1'b0}}};
  localparam logic [F:0] COV_THRESH = (F + 1)'((3 * (2 ** F)) / 10);
  localparam logic [F:0] COV_BOOST  = (F + 1)'((2 ** F + 5) / 10);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PIX0  = 6'b000010,
    S_PIX1  = 6'b000100,
    S_DIV   = 6'b001000,
    S_STEP0 = 6'b010000,
    S_STEP1 = 6'b100000
  } state_t;

  // queue head fields
  alsp_pkg::cmd_t h_kind;
  logic           h_steep, h_neg;
  logic [C-1:0]   h_a0, h_a1, h_b0, h_mag, h_span, h_sx, h_sy, h_ex, h_ey;

  assign h_kind = alsp_pkg::cmd_t'(head_data[ENTRY_W-1]);
  assign {h_steep, h_neg, h_a0, h_a1, h_b0, h_mag, h_span,
          h_sx, h_sy, h_ex, h_ey} = head_data[ENTRY_W-2:0];

  state_t            state_r, state_nxt;
  logic              active_r, active_nxt;
  logic              steep_r, steep_nxt;
  logic [C:0]        major_pos_r, major_pos_nxt;
  logic [C-1:0]      major_end_r, major_end_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [GRAD_W-1:0] grad_r, grad_nxt;
  logic [C-1:0]      ep0_x_r, ep0_x_nxt, ep0_y_r, ep0_y_nxt, ep1_y_r, ep1_y_nxt;
  logic [C:0]        ep1_x_r, ep1_x_nxt;
  logic              ep_last_r, ep_last_nxt;
  logic [C:0]        rem_r, rem_nxt;
  logic [C-1:0]      den_r, den_nxt;
  logic [F:0]        quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [OW-1:0]     opacity_r;

  logic              out_valid_r;
  logic [C:0]        out_x_r, out_y_r;
  logic [OW-1:0]     out_alpha_r;
  logic              out_last_r;

  logic              out_free, emit;
  logic [C:0]        pix_x, pix_y;
  logic [F:0]        cov, cov_adj;
  logic              pix_last;
  logic [C:0]        whole, whole_p1;
  logic [F-1:0]      frac;
  logic              fin;
  logic              div_ge;
  logic [C:0]        div_diff;
  logic [F:0]        div_quo;
  logic [GRAD_W-1:0] div_grad;
  logic [PROD_W-1:0] prod;

  assign out_free = !out_valid_r || out_tready;
  assign whole    = acc_r[ACC_W-1:F];
  assign whole_p1 = whole + 1'b1;
  assign frac     = acc_r[F-1:0];
  assign fin      = major_pos_r >= {1'b0, major_end_r};

  // one restoring-divide bit per cycle: integer bit first, then F fraction bits
  assign div_ge   = rem_r >= {1'b0, den_r};
  assign div_diff = rem_r - {1'b0, den_r};
  assign div_quo  = {quo_r[F-1:0], div_ge};
  assign div_grad = neg_r ? (GRAD_W'(0) - {1'b0, div_quo}) : {1'b0, div_quo};

  always_comb begin
    pix_x    = '0;
    pix_y    = '0;
    cov      = '0;
    pix_last = 1'b0;
    emit     = 1'b0;
    case (state_r)
      S_PIX0: begin
        pix_x = {1'b0, ep0_x_r};
        pix_y = {1'b0, ep0_y_r};
        cov   = COV_ONE;
        emit  = out_free;
      end
      S_PIX1: begin
        pix_x    = ep1_x_r;
        pix_y    = {1'b0, ep1_y_r};
        pix_last = ep_last_r;
        emit     = out_free;
      end
      S_STEP0: begin
        pix_x = steep_r ? whole : major_pos_r;
        pix_y = steep_r ? major_pos_r : whole;
        cov   = COV_ONE - {1'b0, frac};
        emit  = out_free;
      end
      S_STEP1: begin
        pix_x    = steep_r ? whole_p1 : major_pos_r;
        pix_y    = steep_r ? major_pos_r : whole_p1;
        cov      = {1'b0, frac};
        pix_last = fin;
        emit     = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // faint pixels get a coverage boost before the opacity scale
  assign cov_adj = (cov <= COV_THRESH) ? (cov + COV_BOOST) : cov;
  assign prod    = PROD_W'(opacity_r) * PROD_W'(cov_adj);

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    steep_nxt     = steep_r;
    major_pos_nxt = major_pos_r;
    major_end_nxt = major_end_r;
    acc_nxt       = acc_r;
    grad_nxt      = grad_r;
    ep0_x_nxt     = ep0_x_r;
    ep0_y_nxt     = ep0_y_r;
    ep1_x_nxt     = ep1_x_r;
    ep1_y_nxt     = ep1_y_r;
    ep_last_nxt   = ep_last_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    pop           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_stat.head_valid) begin
          pop = 1'b1;
          if (h_kind == alsp_pkg::CMD_LOAD) begin
            steep_nxt     = h_steep;
            major_pos_nxt = {1'b0, h_a0} + 1'b1;
            major_end_nxt = h_a1;
            acc_nxt       = {1'b0, h_b0, {F{1'b0}}};
            grad_nxt      = '0;
            active_nxt    = h_span != '0;
            ep0_x_nxt     = h_sx;
            ep0_y_nxt     = h_sy;
            ep1_x_nxt     = {1'b0, h_ex} + 1'b1;
            ep1_y_nxt     = h_ey;
            ep_last_nxt   = h_span == '0;
            rem_nxt       = {1'b0, h_mag};
            den_nxt       = h_span;
            neg_nxt       = h_neg;
            quo_nxt       = '0;
            cnt_nxt       = '0;
            state_nxt     = S_PIX0;
          end else if (active_r) begin
            state_nxt = S_STEP0;
          end
          // drop a step with no line in progress
        end
      end
      S_PIX0: begin
        if (out_free) begin
          state_nxt = S_PIX1;
        end
      end
      S_PIX1: begin
        if (out_free) begin
          state_nxt = ep_last_r ? S_IDLE : S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? {div_diff[C-1:0], 1'b0} : {rem_r[C-1:0], 1'b0};
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(F)) begin
          grad_nxt  = div_grad;
          state_nxt = S_IDLE;
        end
      end
      S_STEP0: begin
        if (out_free) begin
          state_nxt = S_STEP1;
        end
      end
      S_STEP1: begin
        if (out_free) begin
          major_pos_nxt = major_pos_r + 1'b1;
          acc_nxt       = acc_r + {{(C - 1){grad_r[GRAD_W-1]}}, grad_r};
          if (fin) begin
            active_nxt = 1'b0;
          end
          // chain straight into the next step of the same line
          if (q_stat.head_valid && h_kind == alsp_pkg::CMD_STEP && !fin) begin
            pop       = 1'b1;
            state_nxt = S_STEP0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      opacity_r   <= alsp_pkg::OPACITY_RESET;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        opacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    steep_r     <= steep_nxt;
    major_pos_r <= major_pos_nxt;
    major_end_r <= major_end_nxt;
    acc_r       <= acc_nxt;
    grad_r      <= grad_nxt;
    ep0_x_r     <= ep0_x_nxt;
    ep0_y_r     <= ep0_y_nxt;
    ep1_x_r     <= ep1_x_nxt;
    ep1_y_r     <= ep1_y_nxt;
    ep_last_r   <= ep_last_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    if (emit) begin
      out_x_r     <= pix_x;
      out_y_r     <= pix_y;
      out_alpha_r <= prod[F+OW-1:F];
      out_last_r  <= pix_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_alpha_r, out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

  // PIX_BITS documents the packed pixel width ahead of byte padding
  if (PIX_BITS > OUT_W) begin : g_width_check
    $error("output data width too narrow");
  end

endmodule

[design/antialiased_line_stepper_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antialiased_line_stepper_top: Wu-style antialiased line pixel generator
// Load beats emit two endpoint pixels and set up a line; step beats emit the
// two pixels of the next major column of the line in progress.
// ----------------------------------------------------------------------------
// First pixel path from an empty block: queue, back-end state register, output register.
// Steps: one pixel per cycle while the sink keeps up and step beats are queued.
// Loads: the serial gradient divider retires one quotient bit per cycle and gates
//   the next command.
// Reset: synchronous active-low rst_n; no line loaded, opacity 255, queue empty.
module antialiased_line_stepper_top #(
  parameter int COORD_BITS  = alsp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = alsp_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = alsp_pkg::QUEUE_DEPTH_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * (COORD_BITS + 1) + alsp_pkg::OPACITY_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,   // start_x, start_y, end_x, end_y, pad
  input  logic [0:0]                     in_tuser,   // command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // pixel_x, pixel_y, alpha, pad
  output logic                           out_tlast,  // last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [alsp_pkg::OPACITY_W-1:0] cfg_data    // opacity
);

  localparam int ENTRY_W = 3 + 9 * COORD_BITS;

  alsp_pkg::q_stat_t  q_stat;
  logic               push, pop;
  logic [ENTRY_W-1:0] push_data, head_data;

  assign cfg_ready = 1'b1;

  alsp_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  alsp_fifo #(
    .W     (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .q_stat    (q_stat)
  );

  alsp_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .OUT_W      (OUT_W),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_data  (head_data),
    .q_stat     (q_stat),
    .pop        (pop),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[design/alsp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_checker: port-level checks for the antialiased line stepper
// Watches the result stream and the opacity write port.
// ----------------------------------------------------------------------------
module alsp_checker #(
  parameter int COORD_BITS = alsp_pkg::COORD_BITS_DEF,
  parameter int OUT_W      = 40
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [OUT_W-1:0]               out_tdata,
  input logic                           out_tlast,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [alsp_pkg::OPACITY_W-1:0] cfg_data
);

  localparam int ALPHA_LO = 2 * (COORD_BITS + 1);
  localparam int ALPHA_HI = ALPHA_LO + alsp_pkg::OPACITY_W - 1;

  logic [alsp_pkg::OPACITY_W-1:0] opac_r;

  // shadow of the last opacity written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opac_r <= alsp_pkg::OPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      opac_r <= cfg_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ALPHA_HI:ALPHA_LO] <= opac_r)
    else $error("alpha above line opacity");

endmodule

bind antialiased_line_stepper_top alsp_checker #(
  .COORD_BITS (COORD_BITS),
  .OUT_W      (OUT_W)
) u_alsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data)
);

[verif/alsp_pixel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alsp_pixel_checker: pixel scoreboard for the antialiased line stepper
// Watches the command, opacity and pixel streams. Keeps a private copy of the
// line state, predicts the pixels of every accepted command and compares each
// pixel beat field by field, in order, against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module alsp_pixel_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [47:0]                     in_tdata,   // start_x, start_y, end_x, end_y
  input  logic [0:0]                      in_tuser,   // command
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [39:0]                     out_tdata,  // pixel_x, pixel_y, alpha, pad
  input  logic                            out_tlast,  // last
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [alsp_pkg::OPACITY_W-1:0]  cfg_data,   // opacity
  output int                              mismatches,
  output int                              outstanding
);

  localparam int CB = alsp_pkg::COORD_BITS_DEF;
  localparam int FB = alsp_pkg::FRAC_BITS_DEF;
  localparam int PB = CB + 1;
  localparam int AB = CB + FB + 1;
  localparam longint FULL_COV  = longint'(1) << FB;
  localparam longint COV_FLOOR = (longint'(3) << FB) / 10;
  localparam longint COV_LIFT  = (FULL_COV + 5) / 10;

  typedef struct packed {
    logic [PB-1:0] x;
    logic [PB-1:0] y;
    logic [7:0]    alpha;
    logic          last;
  } pixel_t;

  pixel_t pixel_q[$];

  logic [alsp_pkg::OPACITY_W-1:0] opacity;
  logic [PB-1:0]        col_pos;
  logic [CB-1:0]        col_end;
  logic [AB-1:0]        acc;
  longint               slope;
  logic                 steep;
  logic                 drawing;

  function automatic logic [7:0] alpha_for(input longint cov);
    longint c;
    c = cov;
    // faint pixels get a lift so thin lines do not vanish
    if (c <= COV_FLOOR) c = c + COV_LIFT;
    return 8'((longint'(opacity) * c) >> FB);
  endfunction

  function automatic pixel_t make_pixel(input longint px, input longint py,
                                        input longint cov, input logic fin);
    pixel_t p;
    p.x     = PB'(px);
    p.y     = PB'(py);
    p.alpha = alpha_for(cov);
    p.last  = fin;
    return p;
  endfunction

  task automatic plot_load(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                           input logic [CB-1:0] ex, input logic [CB-1:0] ey);
    longint xs, ys, xe, ye, adx, ady, a0, b0, a1, b1, t, span, db, mag;
    xs = sx;
    ys = sy;
    xe = ex;
    ye = ey;
    adx = (xs > xe) ? xs - xe : xe - xs;
    ady = (ys > ye) ? ys - ye : ye - ys;
    steep = ady > adx;
    if (steep) begin
      a0 = ys; b0 = xs; a1 = ye; b1 = xe;
    end else begin
      a0 = xs; b0 = ys; a1 = xe; b1 = ye;
    end
    if (a1 < a0) begin
      t = a0; a0 = a1; a1 = t;
      t = b0; b0 = b1; b1 = t;
    end
    span = a1 - a0;
    db = b1 - b0;
    if (span == 0) begin
      slope = 0;
    end else begin
      mag = ((db < 0 ? -db : db) << FB) / span;
      slope = (db < 0) ? -mag : mag;
    end
    col_pos = PB'(a0 + 1);
    col_end = CB'(a1);
    acc     = AB'(b0 << FB);
    drawing = span != 0;
    // endpoint pixels: the +1 lands on screen x even for steep lines
    pixel_q.push_back(make_pixel(xs, ys, FULL_COV, 1'b0));
    pixel_q.push_back(make_pixel(xe + 1, ye, 0, span == 0));
  endtask

  task automatic plot_step();
    longint whole, frac, pos;
    logic fin;
    if (!drawing) return;
    whole = acc[AB-1:FB];
    frac  = acc[FB-1:0];
    pos   = col_pos;
    fin   = col_pos >= col_end;
    if (steep) begin
      pixel_q.push_back(make_pixel(whole, pos, FULL_COV - frac, 1'b0));
      pixel_q.push_back(make_pixel(whole + 1, pos, frac, fin));
    end else begin
      pixel_q.push_back(make_pixel(pos, whole, FULL_COV - frac, 1'b0));
      pixel_q.push_back(make_pixel(pos, whole + 1, frac, fin));
    end
    col_pos = col_pos + 1'b1;
    acc     = AB'(longint'(acc) + slope);
    if (fin) drawing = 1'b0;
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      pixel_q.delete();
      opacity    = alsp_pkg::OPACITY_RESET;
      col_pos    = '0;
      col_end    = '0;
      acc        = '0;
      slope      = 0;
      steep      = 1'b0;
      drawing    = 1'b0;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) opacity = cfg_data;
      if (out_tvalid && out_tready) begin
        got.x     = out_tdata[PB-1:0];
        got.y     = out_tdata[2*PB-1:PB];
        got.alpha = out_tdata[2*PB+7:2*PB];
        got.last  = out_tlast;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel x=%0d y=%0d alpha=%0d last=%0b", $time,
                   got.x, got.y, got.alpha, got.last);
          mismatches = mismatches + 1;
        end else begin
          want = pixel_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.alpha !== want.alpha ||
              got.last !== want.last) begin
            $display("%0t: expected x=%0d y=%0d a=%0d l=%0b, got x=%0d y=%0d a=%0d l=%0b",
                     $time, want.x, want.y, want.alpha, want.last,
                     got.x, got.y, got.alpha, got.last);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (alsp_pkg::cmd_t'(in_tuser[0]) == alsp_pkg::CMD_LOAD)
          plot_load(in_tdata[CB-1:0], in_tdata[2*CB-1:CB], in_tdata[3*CB-1:2*CB],
                    in_tdata[4*CB-1:3*CB]);
        else
          plot_step();
      end
    end
    outstanding <= pixel_q.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the antialiased line stepper
// Sends directed lines covering the coordinate extremes and corner cases, then
// random short and long lines with overruns, abandoned lines and noise, under
// several opacity settings, with random gaps, bursts and one long sink stall.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CB     = alsp_pkg::COORD_BITS_DEF;
  localparam int OW     = alsp_pkg::OPACITY_W;
  localparam int IN_W   = ((4 * CB + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * (CB + 1) + OW + 7) / 8) * 8;
  localparam int CMAX   = (1 << CB) - 1;
  localparam int ITEMS  = 1900;
  localparam int PHASES = 5;
  localparam int SETTLE = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;
  logic [0:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [OW-1:0]        cfg_data;
  int                   mismatches;
  int                   outstanding;

  logic in_burst;
  logic out_burst;
  logic hold_off;
  logic random_on;
  int   beats;

  antialiased_line_stepper_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  alsp_pixel_checker pixel_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return CMAX;
      default: return $urandom_range(0, CMAX);
    endcase
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  // Call at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(input alsp_pkg::cmd_t cmd, input int sx, input int sy,
                           input int ex, input int ey);
    int gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_W'({ey[CB-1:0], ex[CB-1:0], sy[CB-1:0], sx[CB-1:0]});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Step payload is ignored by the block; randomize it anyway.
  task automatic step_beat();
    send_beat(alsp_pkg::CMD_STEP, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
              $urandom_range(0, CMAX), $urandom_range(0, CMAX));
  endtask

  task automatic set_opacity(input int level);
    cfg_valid <= 1'b1;
    cfg_data  <= OW'(level);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain all pixels, then give a trailing load time to finish its divide.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_line();
    int kind, sx, sy, ex, ey, reach, adx, ady, span, steps;
    kind = $urandom_range(0, 9);
    sx = pick_coord();
    sy = pick_coord();
    if (kind == 0) begin
      // noise: a lone command of either kind
      if ($urandom_range(0, 1)) begin
        step_beat();
      end else begin
        send_beat(alsp_pkg::CMD_LOAD, sx, sy, pick_coord(), pick_coord());
        beats++;
      end
      return;
    end
    if (kind == 1) begin
      ex = pick_coord();
      ey = pick_coord();
    end else begin
      reach = $urandom_range(0, 12);
      ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
      ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
    end
    adx = (sx > ex) ? sx - ex : ex - sx;
    ady = (sy > ey) ? sy - ey : ey - sy;
    span = (adx > ady) ? adx : ady;
    if (kind == 1) begin
      // long line: walk a few columns, then abandon it
      steps = $urandom_range(0, 6);
    end else begin
      case ($urandom_range(0, 7))
        0:       steps = $urandom_range(0, span);
        1:       steps = span + $urandom_range(1, 2);
        default: steps = span;
      endcase
    end
    send_beat(alsp_pkg::CMD_LOAD, sx, sy, ex, ey);
    repeat (steps) step_beat();
    beats += 1 + ((steps < span) ? steps : span);
  endtask

  // sink side: random stalls, bursts, and the long hold-off
  initial begin
    int stall;
    out_tready <= 1'b0;
    out_burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0 || hold_off) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Stall the sink long enough for the block to back up into its input.
  initial begin
    hold_off <= 1'b0;
    wait (random_on);
    repeat (40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (500) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int levels[PHASES];
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_burst  = 1'b0;
    random_on = 1'b0;
    beats     = 0;
    levels    = '{0, 255, 1, 128, 0};
    levels[PHASES-1] = $urandom_range(2, 254);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines at the reset opacity
    step_beat();                                          // nothing loaded yet
    send_beat(alsp_pkg::CMD_LOAD, 0, 0, CMAX, CMAX);      // full diagonal, end x past range
    step_beat();
    step_beat();
    send_beat(alsp_pkg::CMD_LOAD, CMAX, CMAX, 0, 0);      // reversed, abandons the line
    step_beat();
    send_beat(alsp_pkg::CMD_LOAD, 10, CMAX, 12, 0);       // steep, reversed
    step_beat();
    step_beat();
    send_beat(alsp_pkg::CMD_LOAD, 100, 200, 100, 200);    // single point
    step_beat();
    send_beat(alsp_pkg::CMD_LOAD, CMAX, 7, CMAX - 3, 7);  // horizontal, reversed
    repeat (4) step_beat();                               // last one runs past the end
    send_beat(alsp_pkg::CMD_LOAD, CMAX, 0, CMAX, 3);      // vertical at the right edge
    repeat (3) step_beat();
    send_beat(alsp_pkg::CMD_LOAD, 0, CMAX, 2, CMAX - 2);  // falling diagonal
    repeat (2) step_beat();
    send_beat(alsp_pkg::CMD_LOAD, 0, 0, 10, 3);           // fractional gradient
    step_beat();
    settle();

    random_on = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      set_opacity(levels[p]);
      while (beats < (p + 1) * ITEMS / PHASES) random_line();
      settle();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

[files.f]
design/alsp_pkg.sv
design/alsp_front.sv
design/alsp_fifo.sv
design/alsp_back.sv
design/antialiased_line_stepper_top.sv
design/alsp_checker.sv
verif/alsp_pixel_checker.sv
verif/tb_top.sv
